[hdl/ptc_pkg.sv]
// types shared by the tone curve pipeline modules
package ptc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 5;
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_MAP   = 1'b1;

	// segment selection result, handed from the table to the arithmetic
	typedef struct packed {
		logic                valid;
		logic                bypass;
		logic [SAMPLE_W-1:0] byp_val;
		logic [SAMPLE_W-1:0] x0;
		logic [SAMPLE_W-1:0] x1;
		logic [SAMPLE_W-1:0] y0;
		logic [SAMPLE_W-1:0] y1;
		logic [SAMPLE_W-1:0] sample;
	} sel_t;

	// state carried through the divider stages
	typedef struct packed {
		logic                valid;
		logic                bypass;
		logic [SAMPLE_W-1:0] byp_val;
		logic [SAMPLE_W-1:0] y0;
		logic                neg;
		logic [SAMPLE_W-1:0] dx;
		logic [SAMPLE_W-1:0] rem;
		logic [SAMPLE_W-1:0] dvd;
		logic [SAMPLE_W-1:0] quo;
	} div_t;

endpackage

[hdl/ptc_seg_find.sv]
// anchor table, segment search and anchor selection
module ptc_seg_find #(
	parameter int MAX_ANCHORS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_s1,
	input  logic                          func_s1,
	input  logic [3:0]                    idx_s1,
	input  logic [ptc_pkg::SAMPLE_W-1:0]  ax_s1,
	input  logic [ptc_pkg::SAMPLE_W-1:0]  ay_s1,
	input  logic [ptc_pkg::SAMPLE_W-1:0]  sample_s1,
	input  logic [ptc_pkg::CFG_W-1:0]     anchor_count,
	output ptc_pkg::sel_t                 sel_s3
);
	localparam int IDXW = $clog2(MAX_ANCHORS);
	localparam int CW   = (IDXW + 1 > ptc_pkg::CFG_W) ? IDXW + 1 : ptc_pkg::CFG_W;
	localparam int NSEG = MAX_ANCHORS - 1;
	localparam int SEGW = (NSEG > 1) ? $clog2(NSEG) : 1;

	logic [ptc_pkg::SAMPLE_W-1:0] x_q [MAX_ANCHORS];
	logic [ptc_pkg::SAMPLE_W-1:0] y_q [MAX_ANCHORS];

	logic [CW-1:0]   cnt_n;
	logic [CW-1:0]   used;
	logic [IDXW-1:0] last;
	logic            lt0;
	logic            ge_last;
	logic [NSEG-1:0] inseg;

	logic                         valid_s2;
	logic                         lt0_s2;
	logic                         ge_s2;
	logic [NSEG-1:0]              inseg_s2;
	logic [IDXW-1:0]              last_s2;
	logic [ptc_pkg::SAMPLE_W-1:0] sample_s2;

	logic [IDXW-1:0] seg;
	logic            found;
	ptc_pkg::sel_t   sel;

	// clamp the anchor count to the table
	always_comb begin
		cnt_n = CW'(anchor_count);
		if (cnt_n < CW'(2)) begin
			used = CW'(2);
		end else if (cnt_n > CW'(MAX_ANCHORS)) begin
			used = CW'(MAX_ANCHORS);
		end else begin
			used = cnt_n;
		end
		last = IDXW'(used - CW'(1));
	end

	// anchor table, written as a write transaction leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ANCHORS; i++) begin
				x_q[IDXW'(i)] <= (i == 1) ? 16'hffff : 16'h0000;
				y_q[IDXW'(i)] <= (i == 1) ? 16'hffff : 16'h0000;
			end
		end else if (en && valid_s1 && (func_s1 == ptc_pkg::FUNC_WRITE)
			&& (int'(idx_s1) < MAX_ANCHORS)) begin
			x_q[IDXW'(idx_s1)] <= ax_s1;
			y_q[IDXW'(idx_s1)] <= ay_s1;
		end
	end

	// per-segment compares
	always_comb begin
		lt0     = sample_s1 < x_q[0];
		ge_last = sample_s1 >= x_q[last];
		for (int b = 0; b < NSEG; b++) begin
			inseg[SEGW'(b)] = (b < int'(last)) && (x_q[IDXW'(b)] <= sample_s1)
				&& (sample_s1 < x_q[IDXW'(b + 1)]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && (func_s1 == ptc_pkg::FUNC_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lt0_s2    <= lt0;
			ge_s2     <= ge_last;
			inseg_s2  <= inseg;
			last_s2   <= last;
			sample_s2 <= sample_s1;
		end
	end

	// highest matching segment wins, then pick its anchors
	always_comb begin
		seg   = '0;
		found = 1'b0;
		for (int b = 0; b < NSEG; b++) begin
			if (inseg_s2[SEGW'(b)]) begin
				seg   = IDXW'(b);
				found = 1'b1;
			end
		end
		sel.valid  = valid_s2;
		sel.x0     = x_q[seg];
		sel.x1     = x_q[seg + IDXW'(1)];
		sel.y0     = y_q[seg];
		sel.y1     = y_q[seg + IDXW'(1)];
		sel.sample = sample_s2;
		priority if (lt0_s2) begin
			sel.bypass  = 1'b1;
			sel.byp_val = y_q[0];
		end else if (ge_s2) begin
			sel.bypass  = 1'b1;
			sel.byp_val = y_q[last_s2];
		end else if (!found) begin
			sel.bypass  = 1'b1;
			sel.byp_val = y_q[0];
		end else begin
			sel.bypass  = 1'b0;
			sel.byp_val = y_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_s3 <= '0;
		end else if (en) begin
			sel_s3 <= sel;
		end
	end

endmodule

[hdl/ptc_div_stage.sv]
// one divider stage: two restoring quotient bits
module ptc_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ptc_pkg::div_t d_in,
	output ptc_pkg::div_t d_out
);
	ptc_pkg::div_t                nxt;
	logic [ptc_pkg::SAMPLE_W:0]   trial;

	// shift in a dividend bit, subtract the divisor where it fits
	always_comb begin
		nxt   = d_in;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {nxt.rem, nxt.dvd[ptc_pkg::SAMPLE_W-1]};
			nxt.dvd = {nxt.dvd[ptc_pkg::SAMPLE_W-2:0], 1'b0};
			if (trial >= {1'b0, nxt.dx}) begin
				trial   = trial - {1'b0, nxt.dx};
				nxt.quo = {nxt.quo[ptc_pkg::SAMPLE_W-2:0], 1'b1};
			end else begin
				nxt.quo = {nxt.quo[ptc_pkg::SAMPLE_W-2:0], 1'b0};
			end
			nxt.rem = trial[ptc_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out <= nxt;
		end
	end

endmodule

[hdl/piecewise_linear_tone_curve_core.sv]
// top level of the piecewise linear tone curve pipeline
//
// channel | direction | handshake         | contents
// s_      | in        | s_tvalid/s_tready | s_tuser func, s_tdata anchor and sample fields
// m_      | out       | m_tvalid/m_tready | m_tdata mapped_value, one per map transaction
// cfg_    | in        | cfg_wen           | cfg_wdata anchor_count
//
// one transaction per clock while the output is not stalled; a map result passes through
// the input register, compare, select, multiply, eight two-bit divider stages and add
// reset clears all valid bits and loads the two default anchors at once
// a stalled output freezes the whole pipeline; s_tready follows the output register
module piecewise_linear_tone_curve_core #(
	parameter int MAX_ANCHORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [0:0]  s_tuser,   // func
	input  logic [55:0] s_tdata,   // anchor_index[3:0], anchor_x, anchor_y, sample, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // mapped_value
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata  // anchor_count
);
	localparam int NDIV = ptc_pkg::SAMPLE_W / 2;

	logic                         en;
	logic [ptc_pkg::CFG_W-1:0]    anchor_count_q;
	logic                         valid_s1;
	logic                         func_s1;
	logic [3:0]                   idx_s1;
	logic [ptc_pkg::SAMPLE_W-1:0] ax_s1;
	logic [ptc_pkg::SAMPLE_W-1:0] ay_s1;
	logic [ptc_pkg::SAMPLE_W-1:0] sample_s1;
	ptc_pkg::sel_t                sel_s3;
	ptc_pkg::div_t                div_s4;
	ptc_pkg::div_t                div_chain [NDIV+1];
	logic [ptc_pkg::SAMPLE_W-1:0] dy_mag;
	logic                         dy_neg;
	logic [ptc_pkg::SAMPLE_W-1:0] ds;
	logic [2*ptc_pkg::SAMPLE_W-1:0] prod;
	logic signed [ptc_pkg::SAMPLE_W+1:0] res;
	logic [ptc_pkg::SAMPLE_W-1:0] res_clamp;
	logic                         m_tvalid_q;
	logic [ptc_pkg::SAMPLE_W-1:0] m_tdata_q;

	// global advance: output register empty or being drained
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_count_q <= ptc_pkg::CFG_W'(2);
		end else if (cfg_wen) begin
			anchor_count_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1   <= s_tuser[0];
			idx_s1    <= s_tdata[3:0];
			ax_s1     <= s_tdata[19:4];
			ay_s1     <= s_tdata[35:20];
			sample_s1 <= s_tdata[51:36];
		end
	end

	ptc_seg_find #(
		.MAX_ANCHORS(MAX_ANCHORS)
	) u_seg (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s1(valid_s1),
		.func_s1(func_s1),
		.idx_s1(idx_s1),
		.ax_s1(ax_s1),
		.ay_s1(ay_s1),
		.sample_s1(sample_s1),
		.anchor_count(anchor_count_q),
		.sel_s3(sel_s3)
	);

	// slope numerator: |y1 - y0| times offset into the segment
	always_comb begin
		dy_neg = sel_s3.y1 < sel_s3.y0;
		dy_mag = dy_neg ? (sel_s3.y0 - sel_s3.y1) : (sel_s3.y1 - sel_s3.y0);
		ds     = sel_s3.sample - sel_s3.x0;
		prod   = {{ptc_pkg::SAMPLE_W{1'b0}}, dy_mag} * {{ptc_pkg::SAMPLE_W{1'b0}}, ds};
	end

	// upper half of the product is already below the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s4 <= '0;
		end else if (en) begin
			div_s4.valid   <= sel_s3.valid;
			div_s4.bypass  <= sel_s3.bypass;
			div_s4.byp_val <= sel_s3.byp_val;
			div_s4.y0      <= sel_s3.y0;
			div_s4.neg     <= dy_neg;
			div_s4.dx      <= sel_s3.x1 - sel_s3.x0;
			div_s4.rem     <= prod[2*ptc_pkg::SAMPLE_W-1:ptc_pkg::SAMPLE_W];
			div_s4.dvd     <= prod[ptc_pkg::SAMPLE_W-1:0];
			div_s4.quo     <= '0;
		end
	end

	assign div_chain[0] = div_s4;

	// divider pipeline
	for (genvar g = 0; g < NDIV; g++) begin : g_div
		ptc_div_stage u_div (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.d_in(div_chain[g]),
			.d_out(div_chain[g+1])
		);
	end

	// apply the signed quotient to y0 and clamp
	always_comb begin
		if (div_chain[NDIV].neg) begin
			res = $signed({2'b00, div_chain[NDIV].y0}) - $signed({2'b00, div_chain[NDIV].quo});
		end else begin
			res = $signed({2'b00, div_chain[NDIV].y0}) + $signed({2'b00, div_chain[NDIV].quo});
		end
		priority if (res < 0) begin
			res_clamp = '0;
		end else if (res > $signed(18'h0ffff)) begin
			res_clamp = 16'hffff;
		end else begin
			res_clamp = res[ptc_pkg::SAMPLE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= div_chain[NDIV].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= div_chain[NDIV].bypass ? div_chain[NDIV].byp_val : res_clamp;
		end
	end

	// input side accepts exactly when the pipeline advances
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output register state");

	// a write transaction never turns into a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s1 && (func_s1 == ptc_pkg::FUNC_WRITE)) |=> !u_seg.valid_s2)
		else $error("write transaction produced a result slot");

	// a stall freezes the last divider stage
	a_stall_freezes_div: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(div_chain[NDIV]))
		else $error("divider moved during a stall");

	// non-bypassed results keep the remainder below the divisor
	a_rem_below_dx: assert property (@(posedge clk) disable iff (!arst_n)
		(div_chain[NDIV].valid && !div_chain[NDIV].bypass)
		|-> (div_chain[NDIV].rem < div_chain[NDIV].dx))
		else $error("divider remainder out of range");

endmodule

[dv/testbench.sv]
// self-checking testbench for the piecewise linear tone curve core
module testbench;

	localparam int N_ANCH = 16;
	localparam int LATENCY = 14;

	typedef struct packed {
		logic        func;
		logic [3:0]  idx;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] smp;
	} curve_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [0:0]  s_tuser;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_wen;
	logic [4:0]  cfg_wdata;

	// predictor state
	logic [15:0] curve_x [N_ANCH];
	logic [15:0] curve_y [N_ANCH];
	logic [4:0]  curve_count;

	curve_item_t pending_items[$];
	logic [15:0] expected_levels[$];
	int          error_count;
	int          maps_checked;
	int          writes_sent;
	int          hold_cycles;
	bit          idle_free;
	bit          long_hold_req;

	piecewise_linear_tone_curve_core #(.MAX_ANCHORS(N_ANCH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// overall time limit
	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic logic [15:0] curve_lookup(input logic [15:0] s);
		int n, last, seg;
		bit found;
		longint x0, x1, y0, y1, r;
		n = curve_count;
		if (n < 2) n = 2;
		if (n > N_ANCH) n = N_ANCH;
		last = n - 1;
		found = 0;
		seg = 0;
		if (s < curve_x[0]) return curve_y[0];
		if (s >= curve_x[last]) return curve_y[last];
		// highest segment containing the sample wins
		for (int b = 0; b < last; b++)
			if (curve_x[b] <= s && s < curve_x[b+1]) begin
				seg = b;
				found = 1;
			end
		if (!found) return curve_y[0];
		x0 = curve_x[seg]; x1 = curve_x[seg+1];
		y0 = curve_y[seg]; y1 = curve_y[seg+1];
		r = y0 + ((y1 - y0) * (longint'(s) - x0)) / (x1 - x0);
		if (r < 0) r = 0;
		if (r > 65535) r = 65535;
		return r[15:0];
	endfunction

	task automatic queue_write(input int idx, input int x, input int y);
		curve_item_t it;
		it = '0;
		it.func = ptc_pkg::FUNC_WRITE;
		it.idx = 4'(idx);
		it.ax = 16'(x);
		it.ay = 16'(y);
		it.smp = 16'($urandom);
		pending_items = {pending_items, it};
	endtask

	task automatic queue_map(input int s);
		curve_item_t it;
		it = '0;
		it.func = ptc_pkg::FUNC_MAP;
		it.idx = 4'($urandom);
		it.ax = 16'($urandom);
		it.ay = 16'($urandom);
		it.smp = 16'(s);
		pending_items = {pending_items, it};
	endtask

	// random sorted curve, with a few unordered points and extra zero-width steps when messy
	task automatic queue_curve(input int n, input bit messy);
		int xs [N_ANCH];
		int step;
		xs[0] = $urandom_range(0, 4000);
		for (int i = 1; i < N_ANCH; i++) begin
			step = $urandom_range(0, 65535 / n);
			if (!messy && step == 0) step = 1;
			xs[i] = xs[i-1] + step;
			if (xs[i] > 65535) xs[i] = 65535;
		end
		for (int i = 0; i < N_ANCH; i++)
			queue_write(i, (messy && $urandom_range(0, 5) == 0) ? $urandom : xs[i], $urandom);
	endtask

	// nothing pending, nothing offered, no result outstanding
	task automatic wait_drained();
		wait (pending_items.size() == 0 && !s_tvalid && expected_levels.size() == 0
			&& !m_tvalid);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_count(input int v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= 5'(v);
		@(posedge clk);
		cfg_wen <= 1'b0;
		curve_count = 5'(v);
	endtask

	// driver: pops items, predicts at acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == ptc_pkg::FUNC_WRITE) begin
					curve_x[s_tdata[3:0]] = s_tdata[19:4];
					curve_y[s_tdata[3:0]] = s_tdata[35:20];
					writes_sent++;
				end else
					expected_levels = {expected_levels, curve_lookup(s_tdata[51:36])};
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && (idle_free || $urandom_range(0, 99) >= 33)) begin
					curve_item_t it;
					it = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= it.func;
					s_tdata <= {4'h0, it.smp, it.ay, it.ax, it.idx};
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_levels.size() == 0)
					report_mismatch($sformatf("unexpected result %0d", m_tdata));
				else begin
					logic [15:0] want;
					want = expected_levels.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("mapped_value %0d, want %0d", m_tdata, want));
					maps_checked++;
				end
			end
			if (long_hold_req) begin
				m_tready <= 1'b0;
				hold_cycles++;
				if (hold_cycles >= 200) long_hold_req = 0;
			end else
				m_tready <= idle_free || ($urandom_range(0, 99) >= 33);
		end
	end

	// stimulus sequence
	initial begin
		s_tvalid = 1'b0; s_tuser = '0; s_tdata = '0;
		m_tready = 1'b0; cfg_wen = 1'b0; cfg_wdata = 5'd2;
		error_count = 0; maps_checked = 0; writes_sent = 0;
		hold_cycles = 0; idle_free = 0; long_hold_req = 0;
		for (int i = 0; i < N_ANCH; i++) begin
			curve_x[i] = 0;
			curve_y[i] = 0;
		end
		curve_x[1] = 16'hffff; curve_y[1] = 16'hffff;
		curve_count = 2;
		wait (arst_n);

		// default identity curve, extremes
		queue_map(0); queue_map(1); queue_map(32768); queue_map(65534); queue_map(65535);
		wait_drained();
		// count below two, falling curve, unordered and zero-width anchors
		write_count(0);
		queue_write(0, 100, 65535); queue_write(1, 60000, 0);
		queue_map(99); queue_map(100); queue_map(30000); queue_map(60000);
		queue_write(2, 60000, 500); queue_write(3, 50000, 9000); queue_write(4, 65535, 65535);
		wait_drained();
		write_count(1);
		queue_map(59999);
		wait_drained();
		write_count(5);
		queue_map(55000); queue_map(60000); queue_map(62000); queue_map(65535);
		// slot fifteen written
		queue_write(15, 65535, 1234);
		wait_drained();
		// count above table
		write_count(31);
		queue_map(65535); queue_map(65000);
		wait_drained();

		// random phases across counts
		for (int ph = 0; ph < 12; ph++) begin
			write_count(ph == 0 ? 16 : ph == 1 ? 2 : $urandom_range(0, 31));
			queue_curve($urandom_range(2, 16), ph % 3 == 2);
			idle_free = (ph == 4);
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(0, 19) == 0)
					queue_write($urandom_range(0, 15), $urandom, $urandom);
				else
					queue_map($urandom);
			end
			if (ph == 6) long_hold_req = 1;
			wait_drained();
		end
		idle_free = 0;

		$display("covered %0d anchor writes and %0d checked map results", writes_sent,
			maps_checked);
		$display("anchor counts from 0 to 31 incl. extremes, with a long output stall");
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
